// ----- rtl/bcgt_pkg.sv -----
package bcgt_pkg;

   // opcodes
   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_COMMIT   = 3'd1;
   localparam logic [2:0] OP_WAIT     = 3'd2;
   localparam logic [2:0] OP_COMPLETE = 3'd3;
   localparam logic [2:0] OP_QUERY    = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_TAG  = 3'd1;
   localparam logic [2:0] ST_WAITING  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_TAG_BUSY = 3'd4;
   localparam logic [2:0] ST_NO_CTX   = 3'd5;

   typedef struct packed {
      logic [2:0] opcode;
      logic [2:0] cta_slot;
      logic [4:0] warp_slot;
      logic [7:0] tx_tag;
      logic [7:0] allowed_incomplete;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       warp_waiting;
      logic       release_warp;
      logic       block_warp;
      logic [3:0] pend_count;
   } rsp_type;

   typedef enum logic [4:0] {
      KIND_ADD      = 5'b00001,
      KIND_COMMIT   = 5'b00010,
      KIND_WAIT     = 5'b00100,
      KIND_COMPLETE = 5'b01000,
      KIND_QUERY    = 5'b10000
   } kind_type;

   typedef struct packed {
      req_type  req;
      kind_type kind;
      logic     slot_bad;
      logic     tag_bad;
   } item_type;

   // queue port between front and back
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

endpackage

// ----- rtl/bcgt_front.sv -----
module bcgt_front
   import bcgt_pkg::*;
#(
   parameter int CTA_SLOTS  = 8,
   parameter int WARP_SLOTS = 32,
   parameter int TX_TAGS    = 256
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  req_type   req_data,
   input  logic      clearing,
   output logic      busy,
   output queue_type q_out,
   input  logic      q_pop
);

   item_type   q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   cls;

   // classify the incoming transfer
   always_comb begin
      cls.req      = req_data;
      cls.slot_bad = (32'(req_data.cta_slot) >= CTA_SLOTS) ||
                     (32'(req_data.warp_slot) >= WARP_SLOTS);
      cls.tag_bad  = 32'(req_data.tx_tag) >= TX_TAGS;
      case (req_data.opcode)
         OP_ADD:      cls.kind = KIND_ADD;
         OP_COMMIT:   cls.kind = KIND_COMMIT;
         OP_WAIT:     cls.kind = KIND_WAIT;
         OP_COMPLETE: cls.kind = KIND_COMPLETE;
         default:     cls.kind = KIND_QUERY;
      endcase
   end

   assign busy = (count_ff == 2'd2) || clearing;
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

   assign q_out.valid = count_ff != 2'd0;
   assign q_out.item  = q_mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/bcgt_back.sv -----
module bcgt_back
   import bcgt_pkg::*;
#(
   parameter int CTA_SLOTS     = 8,
   parameter int WARP_SLOTS    = 32,
   parameter int TX_TAGS       = 256,
   parameter int GROUP_SLOTS   = 8,
   parameter int GROUP_ID_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  queue_type q_in,
   output logic      q_pop,
   output logic      clearing,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   localparam int NCTX   = CTA_SLOTS * WARP_SLOTS;
   localparam int CTX_W  = (NCTX > 1) ? $clog2(NCTX) : 1;
   localparam int GS_W   = $clog2(GROUP_SLOTS);
   localparam int GRP_N  = NCTX * GROUP_SLOTS;
   localparam int GRP_W  = $clog2(GRP_N);
   localparam int TAG_W  = $clog2(TX_TAGS);
   localparam int CNT_W  = $clog2(TX_TAGS + 1);
   localparam int PEND_W = $clog2(GROUP_SLOTS + 1);
   localparam int GID_W  = GROUP_ID_BITS;
   localparam int CLR_N  = (GRP_N > TX_TAGS) ? GRP_N : TX_TAGS;
   localparam int CLR_W  = $clog2(CLR_N);

   typedef enum logic [5:0] {
      S_CLR      = 6'b000001,
      S_IDLE     = 6'b000010,
      S_RD1      = 6'b000100,
      S_RD2      = 6'b001000,
      S_SCAN_RD  = 6'b010000,
      S_SCAN_CHK = 6'b100000
   } state_type;

   // memories
   logic [GID_W-1:0]  ctx_nx_mem   [NCTX];
   logic [GID_W-1:0]  ctx_cp_mem   [NCTX];
   logic [GID_W-1:0]  ctx_tgt_mem  [NCTX];
   logic [GS_W-1:0]   ctx_ns_mem   [NCTX];
   logic [PEND_W-1:0] ctx_pd_mem   [NCTX];
   logic              ctx_fl_mem   [NCTX];
   logic              ctx_us_mem   [NCTX];
   logic              tag_vl_mem   [TX_TAGS];
   logic [CTX_W-1:0]  tag_ow_mem   [TX_TAGS];
   logic [GID_W-1:0]  tag_gp_mem   [TX_TAGS];
   logic [CNT_W-1:0]  grp_mem      [GRP_N];

   // registered read data
   logic [GID_W-1:0]  nx_ff, cpr_ff, tgt_ff, tg_ff;
   logic [GS_W-1:0]   ns_ff;
   logic [PEND_W-1:0] pdr_ff;
   logic              fl_ff, us_ff, tv_ff;
   logic [CTX_W-1:0]  tow_ff;
   logic [CNT_W-1:0]  gc_ff;

   // control and work registers
   state_type         state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   item_type          item_ff, item_in;
   logic [CTX_W-1:0]  c_ff, c_in;
   logic [GRP_W-1:0]  ga_ff, ga_in;
   logic [GID_W-1:0]  cp_ff, cp_in;
   logic [PEND_W-1:0] pd_ff, pd_in;
   logic [PEND_W-1:0] n_ff, n_in;
   logic              rv_ff, rv_in;
   rsp_type           rd_ff, rd_in;

   // memory port controls
   logic              ctx_re, tag_re, grp_re;
   logic [CTX_W-1:0]  ctx_ra;
   logic [TAG_W-1:0]  tag_ra;
   logic [GRP_W-1:0]  grp_ra;
   logic              ctx_we, tag_we, grp_we;
   logic [CTX_W-1:0]  ctx_wa;
   logic [TAG_W-1:0]  tag_wa;
   logic [GRP_W-1:0]  grp_wa;
   logic [GID_W-1:0]  w_nx, w_cp, w_tgt, w_tg;
   logic [GS_W-1:0]   w_ns;
   logic [PEND_W-1:0] w_pd;
   logic              w_fl, w_us, w_tv;
   logic [CTX_W-1:0]  w_tow;
   logic [CNT_W-1:0]  w_gc;

   // helpers
   logic [CTX_W-1:0]  cx;
   logic [GID_W-1:0]  one_g, inc, cand, allow_g;
   logic [CNT_W-1:0]  newcnt;
   logic [PEND_W-1:0] pnew;
   logic              fl_fin;

   function automatic logic [GS_W-1:0] slot_of(input logic [GID_W-1:0] nx,
                                                input logic [GID_W-1:0] g,
                                                input logic [GS_W-1:0]  ns);
      logic [GID_W-1:0] diff;
      logic [GS_W-1:0]  d;
      diff = nx - g;
      if (32'(diff) >= GROUP_SLOTS) begin
         d = GS_W'(32'(diff) - GROUP_SLOTS);
      end else begin
         d = GS_W'(diff);
      end
      if (ns >= d) begin
         slot_of = ns - d;
      end else begin
         slot_of = GS_W'(32'(ns) + GROUP_SLOTS - 32'(d));
      end
   endfunction

   function automatic logic [GRP_W-1:0] grp_addr(input logic [CTX_W-1:0] c,
                                                 input logic [GS_W-1:0]  s);
      grp_addr = GRP_W'(32'(c) * GROUP_SLOTS + 32'(s));
   endfunction

   assign one_g   = GID_W'(1);
   assign cx      = CTX_W'(32'(q_in.item.req.cta_slot) * WARP_SLOTS +
                           32'(q_in.item.req.warp_slot));
   assign inc     = nx_ff - cpr_ff - one_g;
   assign allow_g = GID_W'(item_ff.req.allowed_incomplete);
   assign cand    = cp_ff + one_g;
   assign newcnt  = (gc_ff != '0) ? gc_ff - CNT_W'(1) : gc_ff;
   assign pnew    = (pdr_ff != '0) ? pdr_ff - PEND_W'(1) : pdr_ff;
   assign fl_fin  = fl_ff && !((nx_ff - tgt_ff) >= (nx_ff - cp_ff));

   assign clearing = state_ff == S_CLR;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      item_in  = item_ff;
      c_in     = c_ff;
      ga_in    = ga_ff;
      cp_in    = cp_ff;
      pd_in    = pd_ff;
      n_in     = n_ff;
      rv_in    = 1'b0;
      rd_in    = '0;
      q_pop    = 1'b0;
      ctx_re   = 1'b0;
      tag_re   = 1'b0;
      grp_re   = 1'b0;
      ctx_ra   = cx;
      tag_ra   = TAG_W'(q_in.item.req.tx_tag);
      grp_ra   = ga_ff;
      ctx_we   = 1'b0;
      tag_we   = 1'b0;
      grp_we   = 1'b0;
      ctx_wa   = c_ff;
      tag_wa   = TAG_W'(item_ff.req.tx_tag);
      grp_wa   = ga_ff;
      w_nx     = nx_ff;
      w_cp     = cpr_ff;
      w_tgt    = tgt_ff;
      w_ns     = ns_ff;
      w_pd     = pdr_ff;
      w_fl     = fl_ff;
      w_us     = us_ff;
      w_tv     = tv_ff;
      w_tow    = tow_ff;
      w_tg     = tg_ff;
      w_gc     = gc_ff;

      case (state_ff)
         S_CLR: begin
            ctx_we = 32'(clr_ff) < NCTX;
            tag_we = 32'(clr_ff) < TX_TAGS;
            grp_we = 32'(clr_ff) < GRP_N;
            ctx_wa = CTX_W'(clr_ff);
            tag_wa = TAG_W'(clr_ff);
            grp_wa = GRP_W'(clr_ff);
            w_nx   = one_g;
            w_cp   = '0;
            w_tgt  = '0;
            w_ns   = GS_W'(1);
            w_pd   = '0;
            w_fl   = 1'b0;
            w_us   = 1'b0;
            w_tv   = 1'b0;
            w_gc   = '0;
            clr_in = clr_ff + CLR_W'(1);
            if (32'(clr_ff) == CLR_N - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_in.valid) begin
               q_pop = 1'b1;
               if (q_in.item.slot_bad) begin
                  rv_in        = 1'b1;
                  rd_in.status = ST_NO_CTX;
               end else begin
                  ctx_re   = 1'b1;
                  tag_re   = 1'b1;
                  item_in  = q_in.item;
                  c_in     = cx;
                  state_in = S_RD1;
               end
            end
         end
         S_RD1: begin
            rd_in.warp_waiting = fl_ff;
            rd_in.pend_count   = 4'(pdr_ff);
            case (item_ff.kind)
               KIND_ADD: begin
                  if (item_ff.tag_bad) begin
                     rv_in        = 1'b1;
                     rd_in.status = ST_BAD_TAG;
                     state_in     = S_IDLE;
                  end else if (tv_ff) begin
                     rv_in        = 1'b1;
                     rd_in.status = ST_TAG_BUSY;
                     state_in     = S_IDLE;
                  end else begin
                     ga_in    = grp_addr(c_ff, ns_ff);
                     grp_ra   = grp_addr(c_ff, ns_ff);
                     grp_re   = 1'b1;
                     state_in = S_RD2;
                  end
               end
               KIND_COMMIT: begin
                  ga_in    = grp_addr(c_ff, ns_ff);
                  grp_ra   = grp_addr(c_ff, ns_ff);
                  grp_re   = 1'b1;
                  state_in = S_RD2;
               end
               KIND_WAIT: begin
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
                  if (us_ff) begin
                     if (fl_ff) begin
                        rd_in.status = ST_WAITING;
                     end else if (allow_g < inc) begin
                        ctx_we             = 1'b1;
                        w_tgt              = nx_ff - allow_g - one_g;
                        w_fl               = 1'b1;
                        rd_in.block_warp   = 1'b1;
                        rd_in.warp_waiting = 1'b1;
                     end
                  end
               end
               KIND_COMPLETE: begin
                  if (!us_ff) begin
                     rv_in        = 1'b1;
                     rd_in.status = ST_NO_CTX;
                     state_in     = S_IDLE;
                  end else if (item_ff.tag_bad || !tv_ff || tow_ff != c_ff) begin
                     rv_in              = 1'b1;
                     rd_in.status       = ST_BAD_TAG;
                     rd_in.release_warp = !fl_ff;
                     state_in           = S_IDLE;
                  end else begin
                     ga_in    = grp_addr(c_ff, slot_of(nx_ff, tg_ff, ns_ff));
                     grp_ra   = grp_addr(c_ff, slot_of(nx_ff, tg_ff, ns_ff));
                     grp_re   = 1'b1;
                     state_in = S_RD2;
                  end
               end
               default: begin
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RD2: begin
            rd_in.warp_waiting = fl_ff;
            rd_in.pend_count   = 4'(pdr_ff);
            state_in           = S_IDLE;
            case (item_ff.kind)
               KIND_ADD: begin
                  rv_in  = 1'b1;
                  tag_we = 1'b1;
                  w_tv   = 1'b1;
                  w_tow  = c_ff;
                  w_tg   = nx_ff;
                  grp_we = 1'b1;
                  w_gc   = gc_ff + CNT_W'(1);
                  ctx_we = 1'b1;
                  w_us   = 1'b1;
               end
               KIND_COMMIT: begin
                  rv_in  = 1'b1;
                  ctx_we = 1'b1;
                  w_us   = 1'b1;
                  if (gc_ff == '0 && nx_ff == cpr_ff + one_g) begin
                     w_cp = cpr_ff + one_g;
                     w_nx = nx_ff + one_g;
                     w_ns = (32'(ns_ff) == GROUP_SLOTS - 1) ? '0 : ns_ff + GS_W'(1);
                  end else if (32'(GID_W'(nx_ff + one_g - cpr_ff)) > GROUP_SLOTS) begin
                     rd_in.status = ST_OVERFLOW;
                  end else begin
                     if (gc_ff != '0) begin
                        w_pd = pdr_ff + PEND_W'(1);
                     end
                     w_nx = nx_ff + one_g;
                     w_ns = (32'(ns_ff) == GROUP_SLOTS - 1) ? '0 : ns_ff + GS_W'(1);
                  end
                  rd_in.pend_count = 4'(w_pd);
               end
               default: begin
                  // complete of an owned live tag
                  tag_we = 1'b1;
                  w_tv   = 1'b0;
                  grp_we = 1'b1;
                  w_gc   = newcnt;
                  rd_in.release_warp = !fl_ff;
                  if (tg_ff == nx_ff || newcnt != '0) begin
                     rv_in = 1'b1;
                  end else if (tg_ff != cpr_ff + one_g) begin
                     rv_in  = 1'b1;
                     ctx_we = 1'b1;
                     w_pd   = pnew;
                     rd_in.pend_count = 4'(pnew);
                  end else begin
                     cp_in    = tg_ff;
                     pd_in    = pnew;
                     n_in     = '0;
                     state_in = S_SCAN_RD;
                  end
               end
            endcase
         end
         S_SCAN_RD: begin
            if ((nx_ff - cp_ff) <= one_g || 32'(n_ff) == GROUP_SLOTS) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end else begin
               grp_ra   = grp_addr(c_ff, slot_of(nx_ff, cand, ns_ff));
               grp_re   = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (gc_ff != '0) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end else begin
               cp_in    = cand;
               n_in     = n_ff + PEND_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of a completion scan: retire the wait if the target is reached
      if ((state_ff == S_SCAN_RD || state_ff == S_SCAN_CHK) && rv_in) begin
         ctx_we             = 1'b1;
         w_cp               = cp_ff;
         w_pd               = pd_ff;
         w_fl               = fl_fin;
         rd_in.status       = ST_OK;
         rd_in.warp_waiting = fl_fin;
         rd_in.release_warp = !fl_fin;
         rd_in.block_warp   = 1'b0;
         rd_in.pend_count   = 4'(pd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      c_ff    <= c_in;
      ga_ff   <= ga_in;
      cp_ff   <= cp_in;
      pd_ff   <= pd_in;
      n_ff    <= n_in;
      rd_ff   <= rd_in;
   end

   // context memory
   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_nx_mem[ctx_wa]  <= w_nx;
         ctx_cp_mem[ctx_wa]  <= w_cp;
         ctx_tgt_mem[ctx_wa] <= w_tgt;
         ctx_ns_mem[ctx_wa]  <= w_ns;
         ctx_pd_mem[ctx_wa]  <= w_pd;
         ctx_fl_mem[ctx_wa]  <= w_fl;
         ctx_us_mem[ctx_wa]  <= w_us;
      end
      if (ctx_re) begin
         nx_ff  <= ctx_nx_mem[ctx_ra];
         cpr_ff <= ctx_cp_mem[ctx_ra];
         tgt_ff <= ctx_tgt_mem[ctx_ra];
         ns_ff  <= ctx_ns_mem[ctx_ra];
         pdr_ff <= ctx_pd_mem[ctx_ra];
         fl_ff  <= ctx_fl_mem[ctx_ra];
         us_ff  <= ctx_us_mem[ctx_ra];
      end
   end

   // tag table
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_vl_mem[tag_wa] <= w_tv;
         tag_ow_mem[tag_wa] <= w_tow;
         tag_gp_mem[tag_wa] <= w_tg;
      end
      if (tag_re) begin
         tv_ff  <= tag_vl_mem[tag_ra];
         tow_ff <= tag_ow_mem[tag_ra];
         tg_ff  <= tag_gp_mem[tag_ra];
      end
   end

   // per-group outstanding counts
   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[grp_wa] <= w_gc;
      end
      if (grp_re) begin
         gc_ff <= grp_mem[grp_ra];
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

endmodule

// ----- rtl/bulk_copy_group_tracker.sv -----
// Responses: a bad slot is answered from S_IDLE, tag errors, wait, query and
//   unused-context complete from S_RD1, and add, commit and plain complete from S_RD2.
// The back end holds one transfer at a time; a complete that closes the oldest group
//   then walks S_SCAN_RD/S_SCAN_CHK per empty group skipped (GROUP_SLOTS at most).
// Reset: synchronous; afterward the memories are swept over max(NCTX*GROUP_SLOTS,
//   TX_TAGS) addresses (2048 by default) with busy high. The receiver cannot stall.
module bulk_copy_group_tracker
   import bcgt_pkg::*;
#(
   parameter int CTA_SLOTS     = 8,
   parameter int WARP_SLOTS    = 32,
   parameter int TX_TAGS       = 256,
   parameter int GROUP_SLOTS   = 8,
   parameter int GROUP_ID_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // front: classifies each transfer and parks it in a two-entry queue
   // back: context, tag and group-count memories, one item at a time;
   //   a completion that closes the oldest group walks later empty groups
   //   one memory read per step
   queue_type q;
   logic      q_pop;
   logic      clearing;

   bcgt_front #(
      .CTA_SLOTS  (CTA_SLOTS),
      .WARP_SLOTS (WARP_SLOTS),
      .TX_TAGS    (TX_TAGS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .clearing (clearing),
      .busy     (busy),
      .q_out    (q),
      .q_pop    (q_pop)
   );

   bcgt_back #(
      .CTA_SLOTS     (CTA_SLOTS),
      .WARP_SLOTS    (WARP_SLOTS),
      .TX_TAGS       (TX_TAGS),
      .GROUP_SLOTS   (GROUP_SLOTS),
      .GROUP_ID_BITS (GROUP_ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   import bcgt_pkg::*;

   // Tracker state per warp context, updated for each accepted transfer; the
   // expected response of every transfer is queued in acceptance order.
   class group_scoreboard;
      bit              tag_live [256];
      logic [7:0]      tag_ctx  [256];
      logic [15:0]     tag_gid  [256];
      logic [15:0]     next_gid [256];
      logic [15:0]     done_gid [256];
      logic [15:0]     wait_gid [256];
      bit              waiting  [256];
      bit              ctx_used [256];
      int unsigned     pend     [256];
      int unsigned     next_pos [256];
      int unsigned     live_cnt [2048];
      rsp_type         expected_rsp [$];
      int              errors;

      function new();
         for (int i = 0; i < 256; i++) begin
            tag_live[i] = 0;
            next_gid[i] = 16'd1;
            done_gid[i] = 16'd0;
            waiting[i]  = 0;
            ctx_used[i] = 0;
            pend[i]     = 0;
            next_pos[i] = 1;
         end
         foreach (live_cnt[i]) live_cnt[i] = 0;
         errors = 0;
      endfunction

      // storage slot of group id g, counted back from the open group
      function int unsigned slot_of(int unsigned c, logic [15:0] g);
         logic [15:0] d;
         d = next_gid[c] - g;
         return c * 8 + (next_pos[c] + 8 - (d % 8)) % 8;
      endfunction

      function logic [2:0] close_group(int unsigned c);
         int unsigned s;
         logic [15:0] span;
         s = slot_of(c, next_gid[c]);
         span = next_gid[c] + 16'd1 - done_gid[c];
         if (live_cnt[s] == 0 && next_gid[c] == done_gid[c] + 16'd1)
            done_gid[c] = done_gid[c] + 16'd1;
         else if (span > 16'd8)
            return ST_OVERFLOW;
         else if (live_cnt[s] != 0)
            pend[c]++;
         next_gid[c] = next_gid[c] + 16'd1;
         next_pos[c] = (next_pos[c] + 1) % 8;
         return ST_OK;
      endfunction

      function void retire_tag(int unsigned c, int unsigned t);
         logic [15:0] g, cand, lag_tgt, lag_done;
         int unsigned s;
         g = tag_gid[t];
         s = slot_of(c, g);
         tag_live[t] = 0;
         if (live_cnt[s] != 0) live_cnt[s]--;
         if (g == next_gid[c] || live_cnt[s] != 0) return;
         if (pend[c] != 0) pend[c]--;
         if (g != done_gid[c] + 16'd1) return;
         done_gid[c] = g;
         // skip forward over committed groups that are already empty
         for (int n = 0; n < 8; n++) begin
            cand = done_gid[c] + 16'd1;
            if (16'(next_gid[c] - done_gid[c]) <= 16'd1) break;
            if (live_cnt[slot_of(c, cand)] != 0) break;
            done_gid[c] = cand;
         end
         lag_tgt  = next_gid[c] - wait_gid[c];
         lag_done = next_gid[c] - done_gid[c];
         if (waiting[c] && lag_tgt >= lag_done) waiting[c] = 0;
      endfunction

      function void note_transfer(req_type r);
         rsp_type e;
         int unsigned c, t;
         logic [15:0] inc;
         c = 32'({r.cta_slot, r.warp_slot});
         t = 32'(r.tx_tag);
         e = '0;
         case (r.opcode)
            OP_ADD: begin
               if (tag_live[t]) e.status = ST_TAG_BUSY;
               else begin
                  ctx_used[c] = 1;
                  tag_live[t] = 1;
                  tag_ctx[t]  = 8'(c);
                  tag_gid[t]  = next_gid[c];
                  live_cnt[slot_of(c, next_gid[c])]++;
               end
            end
            OP_COMMIT: begin
               ctx_used[c] = 1;
               e.status = close_group(c);
            end
            OP_WAIT: begin
               if (ctx_used[c]) begin
                  if (waiting[c]) e.status = ST_WAITING;
                  else begin
                     inc = next_gid[c] - done_gid[c] - 16'd1;
                     if (16'(r.allowed_incomplete) < inc) begin
                        wait_gid[c] = next_gid[c] - 16'(r.allowed_incomplete) - 16'd1;
                        waiting[c] = 1;
                        e.block_warp = 1;
                     end
                  end
               end
            end
            OP_COMPLETE: begin
               if (!ctx_used[c]) e.status = ST_NO_CTX;
               else begin
                  if (tag_live[t] && tag_ctx[t] == c) retire_tag(c, t);
                  else e.status = ST_BAD_TAG;
                  e.release_warp = !waiting[c];
               end
            end
            default: ;
         endcase
         e.warp_waiting = waiting[c];
         e.pend_count   = 4'(pend[c]);
         expected_rsp.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response with nothing outstanding: %h", a);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
         end
         if (a.warp_waiting !== e.warp_waiting) begin
            $error("warp_waiting exp %0d got %0d", e.warp_waiting, a.warp_waiting);
            errors++;
         end
         if (a.release_warp !== e.release_warp) begin
            $error("release_warp exp %0d got %0d", e.release_warp, a.release_warp);
            errors++;
         end
         if (a.block_warp !== e.block_warp) begin
            $error("block_warp exp %0d got %0d", e.block_warp, a.block_warp); errors++;
         end
         if (a.pend_count !== e.pend_count) begin
            $error("pend_count exp %0d got %0d", e.pend_count, a.pend_count);
            errors++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 20000;   // covers the post-reset memory sweep

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   group_scoreboard sb = new();
   int      idle_cycles = 0;
   bit      gaps_on = 1;
   logic [7:0] ctx_pool [4];

   bulk_copy_group_tracker DUT (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // results cannot be held off: check every strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   // watchdog on cycles without any transfer or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // present one command and hold it until the transfer; start stays high
   task automatic send(req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_transfer(r);
   endtask

   task automatic gap();
      int n;
      int p;
      p = $urandom_range(99);
      n = !gaps_on ? 0 : (p < 65 ? 0 : (p < 95 ? $urandom_range(3, 1)
                                                : $urandom_range(40, 10)));
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // sender pauses until every outstanding result is back
   task automatic drain();
      start <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_type cmd(logic [2:0] op, logic [7:0] c, logic [7:0] t,
                                   logic [7:0] allow);
      req_type r;
      r.opcode = op;
      {r.cta_slot, r.warp_slot} = c;
      r.tx_tag = t;
      r.allowed_incomplete = allow;
      return r;
   endfunction

   // random command biased toward a few busy contexts and a small tag pool,
   // with completes mostly aimed at live tags of their owner
   function automatic req_type random_cmd();
      req_type r;
      int p, t0;
      r = req_type'({$urandom, $urandom});
      r.allowed_incomplete = ($urandom_range(9) < 8) ? 8'($urandom_range(3))
                                                      : 8'($urandom);
      if ($urandom_range(9) < 8) {r.cta_slot, r.warp_slot} = ctx_pool[$urandom_range(3)];
      if ($urandom_range(9) < 8) r.tx_tag = 8'($urandom_range(31));
      p = $urandom_range(99);
      if (p < 32) r.opcode = OP_ADD;
      else if (p < 52) r.opcode = OP_COMMIT;
      else if (p < 62) r.opcode = OP_WAIT;
      else if (p < 92) begin
         r.opcode = OP_COMPLETE;
         if ($urandom_range(9) < 8) begin
            t0 = $urandom_range(255);
            for (int i = 0; i < 256; i++) begin
               if (sb.tag_live[(t0 + i) % 256]) begin
                  r.tx_tag = 8'((t0 + i) % 256);
                  {r.cta_slot, r.warp_slot} = sb.tag_ctx[(t0 + i) % 256];
                  break;
               end
            end
         end
      end else if (p < 96) r.opcode = OP_QUERY;
      else r.opcode = 3'($urandom_range(7, 5));
      return r;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: unused context, busy and foreign tags, block and release,
      // wait while waiting, field extremes, undefined opcodes
      send(cmd(OP_QUERY,    8'd0,   8'd0,   8'd0));
      send(cmd(OP_WAIT,     8'd0,   8'd0,   8'd0));
      send(cmd(OP_COMPLETE, 8'd0,   8'd0,   8'd0));
      send(cmd(OP_ADD,      8'd0,   8'd0,   8'd0));
      send(cmd(OP_ADD,      8'd1,   8'd0,   8'd0));
      send(cmd(OP_COMMIT,   8'd1,   8'd0,   8'd0));
      send(cmd(OP_COMPLETE, 8'd1,   8'd0,   8'd0));
      send(cmd(OP_COMMIT,   8'd0,   8'd0,   8'd0));
      send(cmd(OP_WAIT,     8'd0,   8'd0,   8'd0));
      send(cmd(OP_WAIT,     8'd0,   8'd0,   8'd0));
      send(cmd(OP_COMPLETE, 8'd0,   8'd0,   8'd0));
      send(cmd(OP_COMPLETE, 8'd0,   8'd0,   8'd0));
      send(cmd(OP_ADD,      8'd255, 8'd255, 8'd255));
      send(cmd(OP_COMMIT,   8'd255, 8'd255, 8'd255));
      send(cmd(OP_ADD,      8'd255, 8'd254, 8'd0));
      send(cmd(OP_COMMIT,   8'd255, 8'd0,   8'd0));
      send(cmd(OP_WAIT,     8'd255, 8'd0,   8'd255));
      send(cmd(OP_WAIT,     8'd255, 8'd0,   8'd0));
      send(cmd(OP_COMPLETE, 8'd255, 8'd254, 8'd0));
      send(cmd(OP_COMPLETE, 8'd255, 8'd255, 8'd0));
      send(cmd(3'd5,        8'd255, 8'd0,   8'd0));
      send(cmd(3'd7,        8'd128, 8'd0,   8'd0));
      drain();

      // random phases, each on its own set of busy contexts; one phase
      // runs back to back with no gaps
      for (int ph = 0; ph < 4; ph++) begin
         foreach (ctx_pool[i]) ctx_pool[i] = 8'($urandom);
         gaps_on = (ph != 2);
         for (int n = 0; n < 420; n++) begin
            send(random_cmd());
            gap();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
